// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/ued_pkg.sv =====
// Shared types, character codes and helpers of the escape decoder.
// No dependencies; the decoder modules import this package.
package ued_pkg;

    localparam int unsigned UED_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_UPPER_U   = 8'h55;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;

    // One expansion job: a prefix of held escape characters (backslash,
    // letter, held digits, in that order) followed by an optional tail unit.
    typedef struct packed {
        logic [2:0]      prefix_len;
        logic            has_tail;
        logic [15:0]     tail;
        logic            letter_upper;
        logic [2:0][6:0] digits;
        logic            last;
    } ued_job_t;

    function automatic logic ued_is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_F);
    endfunction

    function automatic logic [3:0] ued_hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d = c - CH_UPPER_A + 8'd10;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            d = c - CH_LOWER_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

// ===== design/ued_in_if.sv =====
// Input byte channel: valid/ready handshake with one text byte per transfer.
// No dependencies.
interface ued_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== design/ued_out_if.sv =====
// Output channel: valid/ready handshake with one UTF-16 code unit per transfer.
// No dependencies.
interface ued_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_of_text;

    modport source (output valid, output code_unit, output last_of_text, input ready);
    modport sink   (input valid, input code_unit, input last_of_text, output ready);
endinterface

// ===== design/unicode_escape_decoder_unit.sv =====
// Backslash-u escape decoder: one text byte in per transfer, UTF-16 code units out.
// Depends on ued_pkg, ued_in_if, ued_out_if, ued_front, ued_queue and ued_back.
//
// The block takes one byte per cycle on byte_stream while the queue is not full
// and turns \uXXXX or \UXXXX (exactly four hex digits) into one 16-bit code
// unit; any other byte comes out zero-extended. A broken escape comes out as the
// characters held so far, as received, followed by the byte that broke it (up to
// six units for one byte), and a byte that ends the text flushes any open escape,
// with last_of_text set on its final unit. The front end classifies each byte in
// the cycle it is taken and writes one job per producing byte into a
// QUEUE_DEPTH-entry queue; the back end sends one code unit per cycle from the
// head job while the output is ready. Input rate is one byte per cycle as long
// as the output takes one unit per cycle and jobs hold one unit each; a broken
// escape or a flush at end of text holds the back end for each of its units, and
// the input stalls once the queue fills. A byte's job is written into the queue
// at the same edge that takes the byte, and, if the queue was empty, its first
// unit is offered in the very next cycle. There is no clearing pass after reset.
module unicode_escape_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = ued_pkg::UED_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ued_in_if.sink    byte_stream,
    ued_out_if.source unit_stream
);
    import ued_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    ued_job_t push_job;
    ued_job_t head_job;

    // classify bytes, hold escape state
    ued_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_stream),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    // decouple classification from expansion
    ued_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // expand each job into its code units
    ued_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head_job (head_job),
        .pop      (q_pop),
        .out_ch   (unit_stream)
    );

endmodule

// ===== design/ued_front.sv =====
// Front end: accepts text bytes, tracks the escape parser and emits jobs.
// Depends on ued_pkg and ued_in_if.
module ued_front (
    input  logic              clk,
    input  logic              rst_n,
    ued_in_if.sink            in_ch,
    input  logic              q_full,
    output logic              q_push,
    output ued_pkg::ued_job_t q_job
);
    import ued_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    mode_t           mode_reg, mode_next;
    logic            letter_reg, letter_next;
    logic [1:0]      count_reg, count_next;
    logic [2:0][6:0] digits_reg, digits_next;
    logic [7:0]      ch;
    logic            fire;

    assign ch          = in_ch.text_byte;
    assign in_ch.ready = !q_full;
    assign fire        = in_ch.valid && !q_full;

    always_comb
    begin
        mode_next   = mode_reg;
        letter_next = letter_reg;
        count_next  = count_reg;
        digits_next = digits_reg;

        q_job.prefix_len = 3'd0;
        q_job.has_tail   = 1'b0;
        q_job.tail       = {8'h00, ch};

        case (mode_reg)
            MODE_IDLE:
            begin
                if (ch == CH_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    q_job.has_tail = 1'b1;
                end
            end
            MODE_ESC:
            begin
                if (ch == CH_LOWER_U || ch == CH_UPPER_U)
                begin
                    letter_next = (ch == CH_UPPER_U);
                    count_next  = 2'd0;
                    mode_next   = MODE_HEX;
                end
                else
                begin
                    // broken: backslash, then the byte
                    q_job.prefix_len = 3'd1;
                    q_job.has_tail   = 1'b1;
                    mode_next        = MODE_IDLE;
                end
            end
            MODE_HEX:
            begin
                if (!ued_is_hex(ch))
                begin
                    q_job.prefix_len = 3'd2 + {1'b0, count_reg};
                    q_job.has_tail   = 1'b1;
                    mode_next        = MODE_IDLE;
                    count_next       = 2'd0;
                end
                else if (count_reg == 2'd3)
                begin
                    q_job.tail = {ued_hex_value({1'b0, digits_reg[0]}),
                                  ued_hex_value({1'b0, digits_reg[1]}),
                                  ued_hex_value({1'b0, digits_reg[2]}),
                                  ued_hex_value(ch)};
                    q_job.has_tail = 1'b1;
                    mode_next      = MODE_IDLE;
                    count_next     = 2'd0;
                end
                else
                begin
                    digits_next[count_reg] = ch[6:0];
                    count_next             = count_reg + 2'd1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // end of text: flush whatever escape is still open
        if (in_ch.end_of_text)
        begin
            if (mode_next == MODE_ESC)
            begin
                q_job.prefix_len = 3'd1;
            end
            else if (mode_next == MODE_HEX)
            begin
                q_job.prefix_len = 3'd2 + {1'b0, count_next};
            end
            mode_next  = MODE_IDLE;
            count_next = 2'd0;
        end

        q_job.letter_upper = letter_next;
        q_job.digits       = digits_next;
        q_job.last         = in_ch.end_of_text;
        q_push = fire && (q_job.prefix_len != 3'd0 || q_job.has_tail);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            letter_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            letter_reg <= letter_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            digits_reg <= digits_next;
        end
    end

endmodule

// ===== design/ued_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on ued_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ued_queue #(
    parameter int unsigned DEPTH = ued_pkg::UED_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ued_pkg::ued_job_t push_job,
    output logic              full,
    input  logic              pop,
    output ued_pkg::ued_job_t head_job,
    output logic              empty
);
    import ued_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ued_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full), "push into full queue")
    `ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty), "pop from empty queue")
    `ASSERT_NEXT(a_cnt_track, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "count lost a push")

endmodule

// ===== design/ued_back.sv =====
// Back end: expands the head job into code units, one per output transfer.
// Depends on ued_pkg, ued_out_if and assert_macros.svh.
`include "assert_macros.svh"

module ued_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  ued_pkg::ued_job_t head_job,
    output logic              pop,
    ued_out_if.source         out_ch
);
    import ued_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  total;
    logic        final_unit;
    logic [15:0] unit;

    assign total      = head_job.prefix_len + {2'b00, head_job.has_tail};
    assign final_unit = (idx_reg == total - 3'd1);

    always_comb
    begin
        unit = head_job.tail;
        if (idx_reg < head_job.prefix_len)
        begin
            case (idx_reg)
                3'd0:    unit = {8'h00, CH_BACKSLASH};
                3'd1:    unit = {8'h00, head_job.letter_upper ? CH_UPPER_U : CH_LOWER_U};
                3'd2:    unit = {9'h000, head_job.digits[0]};
                3'd3:    unit = {9'h000, head_job.digits[1]};
                3'd4:    unit = {9'h000, head_job.digits[2]};
                default: unit = head_job.tail;
            endcase
        end
    end

    assign out_ch.valid        = !empty;
    assign out_ch.code_unit    = unit;
    assign out_ch.last_of_text = head_job.last && final_unit;

    // advance through the job; drop it after its final unit is taken
    assign pop = !empty && out_ch.ready && final_unit;

    always_comb
    begin
        idx_next = idx_reg;
        if (!empty && out_ch.ready)
        begin
            idx_next = final_unit ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 3'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    `ASSERT_ALWAYS(a_idx_in_job, clk, rst_n, empty || (idx_reg < total), "unit index past job end")
    `ASSERT_NEXT(a_idx_restart, clk, rst_n, pop, idx_reg == 3'd0, "index not rewound after pop")

endmodule
